### hdl/lpht_pkg.sv
// Shared types and constants for the linear-probe hash table unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lpht_pkg;

  localparam int KEY_W  = 31;
  localparam int DATA_W = 32;
  localparam int CNT_W  = 9;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  localparam logic [1:0] RES_OK   = 2'd0;
  localparam logic [1:0] RES_MISS = 2'd1;
  localparam logic [1:0] RES_FULL = 2'd2;

  localparam logic [1:0] ST_EMPTY = 2'd0;
  localparam logic [1:0] ST_LIVE  = 2'd1;
  localparam logic [1:0] ST_TOMB  = 2'd2;

  localparam logic [CNT_W-1:0] FILL_RST = 9'd128;
  localparam logic [CNT_W-1:0] CNT_MAX  = 9'h1FF;

  typedef struct packed {
    logic [1:0]        st;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] val;
  } slot_t;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_HOME  = 5'b00100,
    S_PROBE = 5'b01000,
    S_RESP  = 5'b10000
  } state_t;

endpackage

`default_nettype wire

### hdl/linear_probe_hash_table_unit.sv
// Key/value table, open addressing with linear probing, one slot probed per cycle.
// Depends on lpht_pkg.
// Flow: when SLOTS is not a power of two, the home slot comes from a reciprocal key
//   modulo (multiply, subtract, correct) before probing; a probe walks 1 to SLOTS slots.
// Words are taken one at a time: a new word is accepted only in the idle state,
//   once the result of the previous word has gone into the output register.
// Reset: synchronous; then a clearing pass marks every slot empty, during which no
//   word is accepted (fill limit writes are taken).
`timescale 1ns / 1ps
`default_nettype none

module linear_probe_hash_table_unit #(
  parameter int SLOTS = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [lpht_pkg::CNT_W-1:0] cfg_wr_data,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [71:0] in_tdata,   // opcode[1:0], key[32:2], data_in[64:33], zero pad
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [47:0] out_tdata   // status[1:0], data_out[33:2], live_count[42:34], pad
);
  import lpht_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam bit POW2 = ((SLOTS & (SLOTS - 1)) == 0);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
  localparam logic [KEY_W-1:0] SLOTS_K  = KEY_W'(SLOTS);
  localparam logic [KEY_W-1:0] RECIP    = KEY_W'((64'd1 << KEY_W) / SLOTS);
  localparam logic [1:0] HOME_MUL = 2'd0;
  localparam logic [1:0] HOME_SUB = 2'd1;
  localparam logic [1:0] HOME_FIX = 2'd2;

  // slot memory
  slot_t slot_mem [SLOTS];
  slot_t rd_r;
  logic  we;
  logic [IDX_W-1:0] wa, ra;
  slot_t wd;

  always_ff @(posedge clk) begin
    if (we) begin
      slot_mem[wa] <= wd;
    end
    rd_r <= slot_mem[ra];
  end

  state_t state_r, state_nxt;
  logic [IDX_W-1:0] clr_r, clr_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;
  logic [IDX_W-1:0] n_r, n_nxt;
  logic [IDX_W-1:0] free_r, free_nxt;
  logic             free_vld_r, free_vld_nxt;
  logic [KEY_W-1:0] div_r, div_nxt;
  logic [1:0]       home_step_r, home_step_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] limit_r;
  logic [1:0]        op_r;
  logic [KEY_W-1:0]  key_r;
  logic [DATA_W-1:0] data_r;
  logic [1:0]        res_st_r, res_st_nxt;
  logic [DATA_W-1:0] res_data_r, res_data_nxt;
  logic              out_valid_r;
  logic [1:0]        out_st_r;
  logic [DATA_W-1:0] out_data_r;
  logic [CNT_W-1:0]  out_cnt_r;

  logic [1:0]        in_op;
  logic [KEY_W-1:0]  in_key;
  logic [DATA_W-1:0] in_data;
  logic              in_acc;
  assign in_op   = in_tdata[1:0];
  assign in_key  = in_tdata[32:2];
  assign in_data = in_tdata[64:33];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc  = in_tvalid && in_tready;

  // key modulo by reciprocal: the quotient estimate is low by at most one,
  // so one compare and subtract finishes the remainder
  logic [2*KEY_W-1:0] recip_prod;
  logic [KEY_W-1:0]   div_back, div_fix;
  logic [IDX_W-1:0]   home_idx;
  assign recip_prod = (2*KEY_W)'(key_r) * (2*KEY_W)'(RECIP);
  assign div_back   = div_r * SLOTS_K;
  assign div_fix    = (div_r >= SLOTS_K) ? div_r - SLOTS_K : div_r;
  assign home_idx   = div_fix[IDX_W-1:0];

  logic [IDX_W-1:0] pos_inc;
  assign pos_inc = (pos_r == LAST_IDX) ? '0 : pos_r + 1'b1;

  logic hit, empty, tomb, lap_end;
  assign hit     = (rd_r.st == ST_LIVE) && (rd_r.key == key_r);
  assign empty   = (rd_r.st == ST_EMPTY);
  assign tomb    = (rd_r.st == ST_TOMB);
  assign lap_end = (n_r == LAST_IDX);

  logic             cand_vld;
  logic [IDX_W-1:0] cand;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    pos_nxt       = pos_r;
    n_nxt         = n_r;
    free_nxt      = free_r;
    free_vld_nxt  = free_vld_r;
    div_nxt       = div_r;
    home_step_nxt = home_step_r;
    count_nxt     = count_r;
    res_st_nxt    = res_st_r;
    res_data_nxt  = res_data_r;
    we = 1'b0;
    wa = pos_r;
    wd = rd_r;
    ra = pos_r;
    // a tombstone on the last slot of the lap is still a usable slot
    cand_vld = free_vld_r || empty || tomb;
    cand     = free_vld_r ? free_r : pos_r;

    unique case (state_r)
      S_CLEAR: begin
        we = 1'b1;
        wa = clr_r;
        wd = '{st: ST_EMPTY, key: '0, val: '0};
        clr_nxt = clr_r + 1'b1;
        if (clr_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        n_nxt         = '0;
        free_vld_nxt  = 1'b0;
        home_step_nxt = HOME_MUL;
        res_data_nxt  = '0;
        res_st_nxt    = RES_MISS;
        if (POW2) begin
          ra      = in_key[IDX_W-1:0];
          pos_nxt = in_key[IDX_W-1:0];
        end
        if (in_acc) begin
          if (in_op == OP_INSERT || in_op == OP_LOOKUP || in_op == OP_DELETE) begin
            state_nxt = POW2 ? S_PROBE : S_HOME;
          end else begin
            state_nxt = S_RESP;
          end
        end
      end
      S_HOME: begin
        case (home_step_r)
          HOME_MUL: begin
            div_nxt       = recip_prod[2*KEY_W-1:KEY_W];
            home_step_nxt = HOME_SUB;
          end
          HOME_SUB: begin
            div_nxt       = key_r - div_back;
            home_step_nxt = HOME_FIX;
          end
          default: begin
            ra        = home_idx;
            pos_nxt   = home_idx;
            state_nxt = S_PROBE;
          end
        endcase
      end
      S_PROBE: begin
        ra      = pos_inc;
        pos_nxt = pos_inc;
        n_nxt   = n_r + 1'b1;
        if (tomb && !free_vld_r) begin
          free_nxt     = pos_r;
          free_vld_nxt = 1'b1;
        end
        if (hit || empty || lap_end) begin
          state_nxt = S_RESP;
          case (op_r)
            OP_INSERT: begin
              if (hit) begin
                we = 1'b1;
                wd = '{st: ST_LIVE, key: key_r, val: data_r};
                res_st_nxt = RES_OK;
              end else if (count_r >= limit_r || !cand_vld) begin
                res_st_nxt = RES_FULL;
              end else begin
                we = 1'b1;
                wa = cand;
                wd = '{st: ST_LIVE, key: key_r, val: data_r};
                if (count_r != CNT_MAX) begin
                  count_nxt = count_r + 1'b1;
                end
                res_st_nxt = RES_OK;
              end
            end
            OP_LOOKUP: begin
              if (hit) begin
                res_data_nxt = rd_r.val;
                res_st_nxt   = RES_OK;
              end
            end
            OP_DELETE: begin
              if (hit) begin
                we = 1'b1;
                wd = '{st: ST_TOMB, key: rd_r.key, val: rd_r.val};
                if (count_r != '0) begin
                  count_nxt = count_r - 1'b1;
                end
                res_st_nxt = RES_OK;
              end
            end
            default: begin
              res_st_nxt = RES_MISS;
            end
          endcase
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      count_r     <= '0;
      limit_r     <= FILL_RST;
      out_valid_r <= 1'b0;
      free_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_r      <= clr_nxt;
      count_r    <= count_nxt;
      free_vld_r <= free_vld_nxt;
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
      if (state_r == S_RESP && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    n_r         <= n_nxt;
    free_r      <= free_nxt;
    div_r       <= div_nxt;
    home_step_r <= home_step_nxt;
    res_st_r    <= res_st_nxt;
    res_data_r  <= res_data_nxt;
    if (in_acc) begin
      op_r   <= in_op;
      key_r  <= in_key;
      data_r <= in_data;
    end
    if (state_r == S_RESP && (!out_valid_r || out_tready)) begin
      out_st_r   <= res_st_r;
      out_data_r <= res_data_r;
      out_cnt_r  <= count_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_cnt_r, out_data_r, out_st_r};

`ifndef SYNTHESIS
  // live count moves by at most one per operation
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (count_r == $past(count_r) || count_r == $past(count_r) + 1'b1 ||
                      count_r == $past(count_r) - 1'b1))
    else $error("live count jumped");

  // slot memory is written only by the clearing pass or at the end of a probe
  assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (state_r == S_CLEAR || state_r == S_PROBE))
    else $error("slot write outside clear or probe");

  // a new result word only follows the response state
  assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && out_valid_r && !$past(out_valid_r)) |-> $past(state_r == S_RESP))
    else $error("result word without response");

  // probe position stays inside the table
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PROBE) |-> (pos_r <= LAST_IDX))
    else $error("probe position out of range");

  // counts never change while idle
  assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(state_r == S_IDLE)) |-> $stable(count_r))
    else $error("live count changed while idle");
`endif

endmodule

`default_nettype wire

### verif/lpht_checker.sv
// Checker for the linear-probe hash table unit: watches the fill limit port
// and both streams, keeps its own copy of the table and compares every result.
// Depends on lpht_pkg.
`timescale 1ns / 1ps

module lpht_checker #(
  parameter int SLOTS = 256
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [lpht_pkg::CNT_W-1:0] cfg_wr_data,
  input  wire logic              in_tvalid,
  input  wire logic              in_tready,
  input  wire logic [71:0]       in_tdata,   // opcode[1:0], key[32:2], data_in[64:33], pad
  input  wire logic              out_tvalid,
  input  wire logic              out_tready,
  input  wire logic [47:0]       out_tdata,  // status[1:0], data_out[33:2], live_count[42:34], pad
  output int                     fail_count,
  output int                     ops_taken,
  output int                     results_seen,
  output int                     full_seen,
  output int                     miss_seen
);
  import lpht_pkg::*;

  typedef struct packed {
    logic [1:0]        status;
    logic [DATA_W-1:0] value;
    logic [CNT_W-1:0]  live;
  } reply_t;

  logic [1:0]        slot_st  [SLOTS];
  logic [KEY_W-1:0]  slot_key [SLOTS];
  logic [DATA_W-1:0] slot_val [SLOTS];
  logic [CNT_W-1:0]  live_entries;
  logic [CNT_W-1:0]  fill_limit;
  reply_t            replies_due[$];

  // Walk the chain from the home slot; free_at gets the first empty or
  // tombstoned slot before the walk stopped, SLOTS if none.
  function automatic logic probe_chain(input logic [KEY_W-1:0] k, output int hit,
                                       output int free_at);
    int   pos;
    logic found;
    logic done;
    pos     = int'(k % SLOTS);
    free_at = SLOTS;
    hit     = 0;
    found   = 1'b0;
    done    = 1'b0;
    for (int n = 0; n < SLOTS && !done; n++) begin
      if (slot_st[pos] == ST_EMPTY) begin
        if (free_at == SLOTS) free_at = pos;
        done = 1'b1;
      end else if (slot_st[pos] == ST_LIVE) begin
        if (slot_key[pos] == k) begin
          hit   = pos;
          found = 1'b1;
          done  = 1'b1;
        end
      end else if (free_at == SLOTS) begin
        free_at = pos;
      end
      if (!done) pos = (pos + 1) % SLOTS;
    end
    return found;
  endfunction

  function automatic reply_t apply_op(input logic [1:0] op, input logic [KEY_W-1:0] k,
                                      input logic [DATA_W-1:0] value);
    reply_t r;
    int     hit;
    int     free_at;
    r.status = RES_MISS;
    r.value  = '0;
    case (op)
      OP_INSERT: begin
        if (probe_chain(k, hit, free_at)) begin
          slot_val[hit] = value;
          r.status = RES_OK;
        end else if (live_entries >= fill_limit || free_at >= SLOTS) begin
          r.status = RES_FULL;
        end else begin
          slot_st[free_at]  = ST_LIVE;
          slot_key[free_at] = k;
          slot_val[free_at] = value;
          if (live_entries != CNT_MAX) live_entries = live_entries + 1'b1;
          r.status = RES_OK;
        end
      end
      OP_LOOKUP: begin
        if (probe_chain(k, hit, free_at)) begin
          r.value  = slot_val[hit];
          r.status = RES_OK;
        end
      end
      OP_DELETE: begin
        if (probe_chain(k, hit, free_at)) begin
          slot_st[hit] = ST_TOMB;
          if (live_entries != '0) live_entries = live_entries - 1'b1;
          r.status = RES_OK;
        end
      end
      default: ;
    endcase
    r.live = live_entries;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    reply_t got;
    reply_t want;
    int     errs;
    errs = 0;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) slot_st[i] = ST_EMPTY;
      live_entries = '0;
      fill_limit   = FILL_RST;
      replies_due.delete();
      fail_count   <= 0;
      ops_taken    <= 0;
      results_seen <= 0;
      full_seen    <= 0;
      miss_seen    <= 0;
    end else begin
      if (cfg_wr_en) fill_limit = cfg_wr_data;
      // results belong to older words, so settle them before the new one
      if (out_tvalid && out_tready) begin
        got.status = out_tdata[1:0];
        got.value  = out_tdata[33:2];
        got.live   = out_tdata[42:34];
        results_seen <= results_seen + 1;
        if (got.status == RES_FULL) full_seen <= full_seen + 1;
        if (got.status == RES_MISS) miss_seen <= miss_seen + 1;
        if (replies_due.size() == 0) begin
          $display("%0t: unexpected result word: status %0d data %08h live %0d",
                   $time, got.status, got.value, got.live);
          errs++;
        end else begin
          want = replies_due.pop_front();
          if (got.status != want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
            errs++;
          end
          if (got.value != want.value) begin
            $display("%0t: data_out expected %08h got %08h", $time, want.value, got.value);
            errs++;
          end
          if (got.live != want.live) begin
            $display("%0t: live_count expected %0d got %0d", $time, want.live, got.live);
            errs++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        replies_due.push_back(apply_op(in_tdata[1:0], in_tdata[32:2], in_tdata[64:33]));
        ops_taken <= ops_taken + 1;
      end
      if (errs != 0) fail_count <= fail_count + errs;
    end
  end

endmodule

### verif/linear_probe_hash_table_unit_tb.sv
// Top of the hash table testbench: clock, reset, fill limit writes and the
// operation stream, with back-pressure on the result side; lpht_checker judges.
// Depends on lpht_pkg, linear_probe_hash_table_unit and lpht_checker.
`timescale 1ns / 1ps

module linear_probe_hash_table_unit_tb;
  import lpht_pkg::*;

  localparam int SLOTS          = 256;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 300;   // longer than a full-lap probe
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic             clk         = 1'b0;
  logic             rst_n       = 1'b0;
  logic             cfg_wr_en   = 1'b0;
  logic [CNT_W-1:0] cfg_wr_data = '0;
  logic             in_tvalid   = 1'b0;
  wire              in_tready;
  logic [71:0]      in_tdata    = '0;   // opcode[1:0], key[32:2], data_in[64:33], pad
  wire              out_tvalid;
  logic             out_tready  = 1'b0;
  wire  [47:0]      out_tdata;          // status[1:0], data_out[33:2], live_count[42:34], pad

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  bit rx_hold      = 1'b0;
  int hold_count   = 0;
  int idle_cycles  = 0;
  logic [7:0]       cluster_base = '0;
  logic [KEY_W-1:0] seen_keys[$];

  int fail_count;
  int ops_taken;
  int results_seen;
  int full_seen;
  int miss_seen;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  linear_probe_hash_table_unit #(.SLOTS(SLOTS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  lpht_checker #(.SLOTS(SLOTS)) table_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .fail_count  (fail_count),
    .ops_taken   (ops_taken),
    .results_seen(results_seen),
    .full_seen   (full_seen),
    .miss_seen   (miss_seen)
  );

  // Result side: random stalls, or one long hold-off while rx_hold is up.
  always @(posedge clk) begin
    if (rx_hold && hold_count < HOLD_CYCLES) begin
      out_tready <= 1'b0;
      hold_count <= hold_count + 1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
      if (!rx_hold) hold_count <= 0;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles, %0d results outstanding", $time,
               WATCHDOG_LIMIT, ops_taken - results_seen);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_word(input logic [1:0] op, input logic [KEY_W-1:0] k,
                           input logic [DATA_W-1:0] value);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, value, k, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (op == OP_INSERT) seen_keys.push_back(k);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (ops_taken != results_seen) @(posedge clk);
  endtask

  task automatic write_fill_limit(input logic [CNT_W-1:0] lim);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= lim;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  function automatic logic [KEY_W-1:0] fresh_key(input logic [7:0] home);
    logic [KEY_W-1:0] k;
    k      = KEY_W'($urandom);
    k[7:0] = home;
    return k;
  endfunction

  // Reuses keys already sent for insert unless a fresh key is drawn (fresh_pct percent),
  // so lookups and deletes can hit; most fresh keys crowd around cluster_base to build long chains.
  function automatic logic [KEY_W-1:0] pick_key(input int fresh_pct);
    if (seen_keys.size() == 0 || $urandom_range(0, 99) < fresh_pct) begin
      if ($urandom_range(0, 9) == 0) return KEY_W'($urandom);
      return fresh_key(cluster_base + 8'($urandom_range(0, 11)));
    end
    return seen_keys[$urandom_range(0, seen_keys.size() - 1)];
  endfunction

  task automatic run_mix(input int count, input int ins_pct, input int del_pct,
                         input int fresh_pct);
    int               left;
    int               r;
    logic [1:0]       op;
    logic [KEY_W-1:0] k;
    left = count;
    while (left > 0) begin
      if (left >= 5 && $urandom_range(0, 99) < 15) begin
        // whole life of one key: add, find, overwrite, remove, miss
        k = fresh_key(cluster_base + 8'($urandom_range(0, 11)));
        send_word(OP_INSERT, k, $urandom);
        send_word(OP_LOOKUP, k, $urandom);
        send_word(OP_INSERT, k, $urandom);
        send_word(OP_DELETE, k, $urandom);
        send_word(OP_LOOKUP, k, $urandom);
        left -= 5;
      end else begin
        r = $urandom_range(0, 99);
        if (r < ins_pct) op = OP_INSERT;
        else if (r < ins_pct + del_pct) op = OP_DELETE;
        else if (r < 97) op = OP_LOOKUP;
        else op = OP_UNUSED;
        send_word(op, pick_key(fresh_pct), $urandom);
        left--;
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty table, wrap-around chains, tombstones, limit edges
    send_word(OP_LOOKUP, 31'd0, 32'h0);
    send_word(OP_DELETE, 31'd5, 32'h0);
    send_word(OP_UNUSED, 31'h7FFFFFFF, 32'hFFFFFFFF);
    send_word(OP_INSERT, 31'd0, 32'h7FFFFFFF);
    send_word(OP_INSERT, 31'h7FFFFFFF, 32'h80000000);
    send_word(OP_INSERT, 31'd256, 32'h0);
    send_word(OP_INSERT, 31'd511, 32'hFFFFFFFF);   // home 255 busy, wraps to slot 2
    send_word(OP_LOOKUP, 31'd511, 32'h0);
    send_word(OP_INSERT, 31'd0, 32'hFFFFFFFF);
    send_word(OP_LOOKUP, 31'd0, 32'h0);
    send_word(OP_DELETE, 31'd256, 32'h0);
    send_word(OP_LOOKUP, 31'd511, 32'h0);          // must pass the tombstone
    send_word(OP_INSERT, 31'd511, 32'd1);          // update, not a tombstone reuse
    send_word(OP_INSERT, 31'd768, 32'd2);          // new key takes the tombstone
    send_word(OP_DELETE, 31'd256, 32'h0);
    send_word(OP_LOOKUP, 31'd256, 32'h0);
    write_fill_limit(9'd0);
    send_word(OP_INSERT, 31'd1024, 32'h5A5A5A5A);
    send_word(OP_INSERT, 31'd768, 32'd3);          // live key still updates
    write_fill_limit(9'd4);
    send_word(OP_INSERT, 31'd9, 32'h12345678);
    write_fill_limit(9'd5);
    send_word(OP_INSERT, 31'd9, 32'h12345678);
    send_word(OP_DELETE, 31'd0, 32'h0);
    send_word(OP_LOOKUP, 31'd0, 32'h0);
    send_word(OP_INSERT, 31'h2AAAAAAA, 32'hAAAAAAAA);

    // no idling, reset limit
    write_fill_limit(FILL_RST);
    cluster_base = 8'($urandom);
    run_mix(250, 45, 20, 40);

    // limit of one, sparse sender
    write_fill_limit(9'd1);
    tx_idle_pct = 71;
    cluster_base = 8'($urandom);
    run_mix(100, 50, 25, 50);

    // fill every slot, then probe full laps on a stalling receiver
    write_fill_limit(9'd256);
    tx_idle_pct  = 0;
    rx_stall_pct = 71;
    for (int i = 0; i < 280; i++) send_word(OP_INSERT, fresh_key(8'(i)), $urandom);
    cluster_base = 8'($urandom);
    run_mix(70, 30, 10, 60);

    // limit above the table size
    write_fill_limit(CNT_MAX);
    tx_idle_pct  = 12;
    rx_stall_pct = 12;
    run_mix(300, 40, 30, 30);

    // random limit; long receiver hold-off, then a full drain mid-phase
    write_fill_limit(9'($urandom_range(2, 200)));
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    cluster_base = 8'($urandom);
    rx_hold = 1'b1;
    run_mix(20, 50, 20, 40);
    rx_hold = 1'b0;
    tx_idle_pct  = 12;
    rx_stall_pct = 12;
    run_mix(140, 35, 40, 30);
    wait_drained();
    run_mix(140, 45, 25, 40);

    wait_drained();
    rx_stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d table operations across fill limits 0 to 511, a full table,",
             ops_taken);
    $display("wrapped chains and tombstones; %0d results, %0d full, %0d not found.",
             results_seen, full_seen, miss_seen);
    if (fail_count == 0 && ops_taken == results_seen) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### files.f
hdl/lpht_pkg.sv
hdl/linear_probe_hash_table_unit.sv
verif/lpht_checker.sv
verif/linear_probe_hash_table_unit_tb.sv
